// ----- src/pietv_pkg.sv -----
// ----------------------------------------------------------------------------
// pietv_pkg
// types and codes shared by the extruded triangle volume test
// ----------------------------------------------------------------------------
package pietv_pkg;

	typedef enum logic [1:0] {
		REQ_VERTEX   = 2'd0,
		REQ_TRIANGLE = 2'd1,
		REQ_QUERY    = 2'd2,
		REQ_NONE     = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		CFG_ENABLED   = 3'd0,
		CFG_EXTRUSION = 3'd1,
		CFG_VBASE     = 3'd2,
		CFG_VTOTAL    = 3'd3,
		CFG_TBASE     = 3'd4,
		CFG_TTOTAL    = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRD,
		ST_TCHK,
		ST_VA,
		ST_VB,
		ST_VC,
		ST_DIFF,
		ST_MAC,
		ST_DRAIN,
		ST_CHK,
		ST_FIN,
		ST_DONE
	} state_t;

	// accumulator destination on the last product of a group
	typedef enum logic [2:0] {
		DST_NONE,
		DST_D,
		DST_N1,
		DST_N2,
		DST_T,
		DST_E
	} dest_t;

	typedef struct packed {
		logic  shift;
		logic  sub;
		logic  clear;
		dest_t dest;
	} mac_ctl_t;

	localparam int ACC_W   = 80;
	localparam int PART_SH = 26;
	localparam logic [3:0] STEP_A_LAST = 4'd5;
	localparam logic [3:0] STEP_B_FIRST = 4'd6;
	localparam logic [3:0] STEP_B_LAST = 4'd15;

endpackage

// ----- src/point_in_extruded_triangle_volume_unit.sv -----
// ----------------------------------------------------------------------------
// point_in_extruded_triangle_volume_unit
// stores vertices and triangles and tests query points against one volume
// ----------------------------------------------------------------------------
// Items of req_type vertex or triangle write one entry of the vertex or
// triangle memory and give no result; a query item gives one contained bit.
// One item is handled at a time. A query walks the triangle window in
// order; each triangle costs a triangle read, three reads of the
// single-port vertex memory and up to sixteen products through one shared
// 27x25 multiplier with an 80-bit accumulator. Queries on a disabled,
// empty or overflowing volume skip the walk. The result waits in an output
// register; the next item is taken once the walk is done.
// ----------------------------------------------------------------------------
module point_in_extruded_triangle_volume_unit #(
	parameter int VERTEX_DEPTH   = 256,
	parameter int TRIANGLE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	// item channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [7:0]         entry_index,
	input  logic signed [23:0] coord_x,
	input  logic signed [23:0] coord_y,
	input  logic signed [23:0] coord_z,
	input  logic [7:0]         corner_a,
	input  logic [7:0]         corner_b,
	input  logic [7:0]         corner_c,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic               contained,
	// register writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [22:0]        cfg_data
);

	localparam int VAW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
	localparam int TAW = (TRIANGLE_DEPTH > 1) ? $clog2(TRIANGLE_DEPTH) : 1;
	localparam int CW  = 14;
	localparam logic [CW-1:0] VD = CW'(VERTEX_DEPTH);
	localparam logic [CW-1:0] TD = CW'(TRIANGLE_DEPTH);

	// configuration registers
	logic        enabled_q;
	logic [22:0] extrusion_q;
	logic [8:0]  vbase_q, vtotal_q, tbase_q, ttotal_q;

	pietv_pkg::state_t state_q, state_d;

	// memories
	logic [71:0] vmem [VERTEX_DEPTH];
	logic [23:0] tmem [TRIANGLE_DEPTH];
	logic [71:0] vrd_q;
	logic [23:0] trd_q;
	logic [VAW-1:0] vaddr;
	logic [TAW-1:0] taddr;

	// walk state
	logic [CW-1:0] row_q;
	logic [8:0]    left_q;
	logic [3:0]    step_q;
	logic          res_valid_q, res_q, pend_q;

	// query point and corners
	logic signed [23:0] px_q, py_q, pz_q;
	logic signed [23:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q, cx_q, cy_q, cz_q;
	logic signed [24:0] e1_q, e2_q, e3_q, e4_q, g_q, u_q, v_q;

	// mac pipe
	logic signed [26:0] mac_a;
	logic signed [24:0] mac_b;
	pietv_pkg::mac_ctl_t mac_ctl, ctl_s1;
	logic               vld_s1;
	logic signed [51:0] prod_s1;
	logic signed [pietv_pkg::ACC_W-1:0] acc_q, acc_sum, acc_term;

	// plan results and normalized weights
	logic signed [50:0] d_q, n1_q, n2_q;
	logic [50:0] dd_q, m1_q, m2_q, m3_q;
	logic signed [pietv_pkg::ACC_W-1:0] t_q, e_q;

	// handshake decode
	logic acc_in, is_query, is_vwr, is_twr, vol_ok, last_tri, out_free;
	logic [CW-1:0] idx_w;

	assign cfg_ready = 1'b1;
	assign out_valid = res_valid_q;
	assign contained = res_q;
	assign acc_in    = in_valid && in_ready;
	assign is_query  = pietv_pkg::req_t'(req_type) == pietv_pkg::REQ_QUERY;
	assign idx_w     = CW'(entry_index);
	assign is_vwr    = pietv_pkg::req_t'(req_type) == pietv_pkg::REQ_VERTEX && idx_w < VD;
	assign is_twr    = pietv_pkg::req_t'(req_type) == pietv_pkg::REQ_TRIANGLE && idx_w < TD;
	assign last_tri  = left_q == 9'd1;
	assign out_free  = !res_valid_q || out_ready;

	// both windows must fit their stores, the triangle window must not be empty and the volume must be enabled
	assign vol_ok = enabled_q
		&& CW'(vbase_q) <= VD && CW'(vtotal_q) <= VD - CW'(vbase_q)
		&& CW'(tbase_q) <= TD && CW'(ttotal_q) <= TD - CW'(tbase_q)
		&& ttotal_q != 9'd0;

	// triangle corner check
	logic [7:0] ia, ib, ic;
	logic       bad_corner;
	assign ia = trd_q[7:0];
	assign ib = trd_q[15:8];
	assign ic = trd_q[23:16];
	assign bad_corner = {1'b0, ia} >= vtotal_q || {1'b0, ib} >= vtotal_q
		|| {1'b0, ic} >= vtotal_q;

	// plan area sign normalization
	logic signed [52:0] w3, dn, w1n, w2n, w3n;
	logic               skip;
	always_comb begin
		w3  = 53'(d_q) - 53'(n1_q) - 53'(n2_q);
		dn  = d_q[50] ? -53'(d_q) : 53'(d_q);
		w1n = d_q[50] ? -53'(n1_q) : 53'(n1_q);
		w2n = d_q[50] ? -53'(n2_q) : 53'(n2_q);
		w3n = d_q[50] ? -w3 : w3;
		skip = (d_q == '0) || w1n[52] || w2n[52] || w3n[52];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pietv_pkg::ST_IDLE: begin
				if (in_valid && is_query)
					state_d = vol_ok ? pietv_pkg::ST_TRD : pietv_pkg::ST_DONE;
			end
			pietv_pkg::ST_TRD:  state_d = pietv_pkg::ST_TCHK;
			pietv_pkg::ST_TCHK: state_d = bad_corner ? pietv_pkg::ST_DONE : pietv_pkg::ST_VA;
			pietv_pkg::ST_VA:   state_d = pietv_pkg::ST_VB;
			pietv_pkg::ST_VB:   state_d = pietv_pkg::ST_VC;
			pietv_pkg::ST_VC:   state_d = pietv_pkg::ST_DIFF;
			pietv_pkg::ST_DIFF: state_d = pietv_pkg::ST_MAC;
			pietv_pkg::ST_MAC: begin
				if (step_q == pietv_pkg::STEP_A_LAST || step_q == pietv_pkg::STEP_B_LAST)
					state_d = pietv_pkg::ST_DRAIN;
			end
			pietv_pkg::ST_DRAIN: begin
				state_d = (step_q == pietv_pkg::STEP_B_FIRST) ? pietv_pkg::ST_CHK
					: pietv_pkg::ST_FIN;
			end
			pietv_pkg::ST_CHK: begin
				if (!skip)
					state_d = pietv_pkg::ST_MAC;
				else
					state_d = last_tri ? pietv_pkg::ST_DONE : pietv_pkg::ST_TRD;
			end
			pietv_pkg::ST_FIN:  state_d = pietv_pkg::ST_DONE;
			pietv_pkg::ST_DONE: if (out_free) state_d = pietv_pkg::ST_IDLE;
			default:            state_d = pietv_pkg::ST_IDLE;
		endcase
	end

	// outputs: handshake, memory addresses, multiplier operands
	logic [CW-1:0] vsel;
	always_comb begin
		in_ready = state_q == pietv_pkg::ST_IDLE;
		taddr    = row_q[TAW-1:0];
		unique case (state_q)
			pietv_pkg::ST_VA: vsel = CW'(vbase_q) + CW'(ib);
			pietv_pkg::ST_VB: vsel = CW'(vbase_q) + CW'(ic);
			default:          vsel = CW'(vbase_q) + CW'(ia);
		endcase
		vaddr   = vsel[VAW-1:0];
		mac_a   = '0;
		mac_b   = '0;
		mac_ctl = '{shift: 1'b0, sub: 1'b0, clear: 1'b0, dest: pietv_pkg::DST_NONE};
		unique case (step_q)
			4'd0:  begin mac_a = 27'(e1_q); mac_b = e4_q; mac_ctl.clear = 1'b1; end
			4'd1:  begin mac_a = 27'(e2_q); mac_b = g_q; mac_ctl.dest = pietv_pkg::DST_D; end
			4'd2:  begin mac_a = 27'(e1_q); mac_b = u_q; mac_ctl.clear = 1'b1; end
			4'd3:  begin mac_a = 27'(e2_q); mac_b = v_q; mac_ctl.dest = pietv_pkg::DST_N1; end
			4'd4:  begin mac_a = 27'(e3_q); mac_b = u_q; mac_ctl.clear = 1'b1; end
			4'd5:  begin mac_a = 27'(e4_q); mac_b = v_q; mac_ctl.dest = pietv_pkg::DST_N2; end
			4'd6:  begin
				mac_a = {1'b0, dd_q[25:0]}; mac_b = 25'(pz_q); mac_ctl.clear = 1'b1;
			end
			4'd7:  begin
				mac_a = {2'b0, dd_q[50:26]}; mac_b = 25'(pz_q); mac_ctl.shift = 1'b1;
			end
			4'd8:  begin mac_a = {1'b0, m1_q[25:0]}; mac_b = 25'(az_q); mac_ctl.sub = 1'b1; end
			4'd9:  begin
				mac_a = {2'b0, m1_q[50:26]}; mac_b = 25'(az_q);
				mac_ctl.sub = 1'b1; mac_ctl.shift = 1'b1;
			end
			4'd10: begin mac_a = {1'b0, m2_q[25:0]}; mac_b = 25'(bz_q); mac_ctl.sub = 1'b1; end
			4'd11: begin
				mac_a = {2'b0, m2_q[50:26]}; mac_b = 25'(bz_q);
				mac_ctl.sub = 1'b1; mac_ctl.shift = 1'b1;
			end
			4'd12: begin mac_a = {1'b0, m3_q[25:0]}; mac_b = 25'(cz_q); mac_ctl.sub = 1'b1; end
			4'd13: begin
				mac_a = {2'b0, m3_q[50:26]}; mac_b = 25'(cz_q);
				mac_ctl.sub = 1'b1; mac_ctl.shift = 1'b1; mac_ctl.dest = pietv_pkg::DST_T;
			end
			4'd14: begin
				mac_a = {1'b0, dd_q[25:0]}; mac_b = {2'b0, extrusion_q}; mac_ctl.clear = 1'b1;
			end
			4'd15: begin
				mac_a = {2'b0, dd_q[50:26]}; mac_b = {2'b0, extrusion_q};
				mac_ctl.shift = 1'b1; mac_ctl.dest = pietv_pkg::DST_E;
			end
			default: ;
		endcase
	end

	// memories: written only from idle, read data used only during a walk, so no overlap
	always_ff @(posedge clk) begin
		if (acc_in && is_vwr)
			vmem[idx_w[VAW-1:0]] <= {coord_z, coord_y, coord_x};
		vrd_q <= vmem[vaddr];
	end

	always_ff @(posedge clk) begin
		if (acc_in && is_twr)
			tmem[idx_w[TAW-1:0]] <= {corner_c, corner_b, corner_a};
		trd_q <= tmem[taddr];
	end

	// accumulate: product, optionally shifted, added or subtracted
	always_comb begin
		acc_term = ctl_s1.shift ? (pietv_pkg::ACC_W'(prod_s1) <<< pietv_pkg::PART_SH)
			: pietv_pkg::ACC_W'(prod_s1);
		if (ctl_s1.sub)
			acc_term = -acc_term;
		acc_sum = (ctl_s1.clear ? '0 : acc_q) + acc_term;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_s1 <= mac_a * mac_b;
		ctl_s1  <= mac_ctl;
		if (acc_in) begin
			px_q <= coord_x;
			py_q <= coord_y;
			pz_q <= coord_z;
		end
		if (state_q == pietv_pkg::ST_VA) begin
			ax_q <= vrd_q[23:0]; ay_q <= vrd_q[47:24]; az_q <= vrd_q[71:48];
		end
		if (state_q == pietv_pkg::ST_VB) begin
			bx_q <= vrd_q[23:0]; by_q <= vrd_q[47:24]; bz_q <= vrd_q[71:48];
		end
		if (state_q == pietv_pkg::ST_VC) begin
			cx_q <= vrd_q[23:0]; cy_q <= vrd_q[47:24]; cz_q <= vrd_q[71:48];
		end
		if (state_q == pietv_pkg::ST_DIFF) begin
			e1_q <= 25'(by_q) - 25'(cy_q);
			e2_q <= 25'(cx_q) - 25'(bx_q);
			e3_q <= 25'(cy_q) - 25'(ay_q);
			e4_q <= 25'(ax_q) - 25'(cx_q);
			g_q  <= 25'(ay_q) - 25'(cy_q);
			u_q  <= 25'(px_q) - 25'(cx_q);
			v_q  <= 25'(py_q) - 25'(cy_q);
		end
		if (vld_s1) begin
			acc_q <= acc_sum;
			case (ctl_s1.dest)
				pietv_pkg::DST_D:  d_q  <= acc_sum[50:0];
				pietv_pkg::DST_N1: n1_q <= acc_sum[50:0];
				pietv_pkg::DST_N2: n2_q <= acc_sum[50:0];
				pietv_pkg::DST_T:  t_q  <= acc_sum;
				pietv_pkg::DST_E:  e_q  <= acc_sum;
				default: ;
			endcase
		end
		if (state_q == pietv_pkg::ST_CHK) begin
			dd_q <= dn[50:0];
			m1_q <= w1n[50:0];
			m2_q <= w2n[50:0];
			m3_q <= w3n[50:0];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pietv_pkg::ST_IDLE;
			enabled_q   <= 1'b0;
			extrusion_q <= '0;
			vbase_q     <= '0;
			vtotal_q    <= '0;
			tbase_q     <= '0;
			ttotal_q    <= '0;
			row_q       <= '0;
			left_q      <= '0;
			step_q      <= '0;
			vld_s1      <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= state_q == pietv_pkg::ST_MAC;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					pietv_pkg::CFG_ENABLED:   enabled_q   <= cfg_data[0];
					pietv_pkg::CFG_EXTRUSION: extrusion_q <= cfg_data;
					pietv_pkg::CFG_VBASE:     vbase_q     <= cfg_data[8:0];
					pietv_pkg::CFG_VTOTAL:    vtotal_q    <= cfg_data[8:0];
					pietv_pkg::CFG_TBASE:     tbase_q     <= cfg_data[8:0];
					pietv_pkg::CFG_TTOTAL:    ttotal_q    <= cfg_data[8:0];
					default: ;
				endcase
			end
			if (res_valid_q && out_ready)
				res_valid_q <= 1'b0;
			unique case (state_q)
				pietv_pkg::ST_IDLE: begin
					row_q  <= CW'(tbase_q);
					left_q <= ttotal_q;
					step_q <= '0;
					pend_q <= 1'b0;
				end
				pietv_pkg::ST_MAC: step_q <= step_q + 4'd1;
				pietv_pkg::ST_CHK: begin
					if (skip) begin
						row_q  <= row_q + CW'(1);
						left_q <= left_q - 9'd1;
						step_q <= '0;
					end
				end
				pietv_pkg::ST_FIN: pend_q <= !t_q[pietv_pkg::ACC_W-1] && (t_q <= e_q);
				pietv_pkg::ST_DONE: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_q       <= pend_q;
					end
				end
				default: ;
			endcase
		end
	end

	// a plan check only reads finished sums
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pietv_pkg::ST_CHK |-> !vld_s1)
		else $error("plan check with products in flight");

	// a finished query always posts its result
	a_post: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pietv_pkg::ST_DONE && out_free) |=> res_valid_q)
		else $error("result not posted");

	// a query on a disabled volume skips the walk
	a_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && is_query && !enabled_q) |=> state_q == pietv_pkg::ST_DONE)
		else $error("disabled volume was walked");

endmodule
